// ----- design/ps2mt_pkg.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Shared constants, register indexes and the byte item type.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int SIZE_BITS      = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam int BUTTON_BITS    = 3;
    localparam int SYNC_BIT       = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RST = 13'd768;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_item_t;

endpackage

// ----- design/ps2_mouse_packet_cursor_tracker.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor tracker
// Decodes three-byte mouse packets into a clamped cursor and button report.
// ----------------------------------------------------------------------------
// Raw mouse bytes enter on in_valid/in_ready with rx_byte. A byte offered as
// the first byte of a packet is dropped unless its bit 3 is set. Every third
// byte completes a packet and yields one item on out_valid/out_ready with
// cursor_x, cursor_y and buttons.
// A byte is registered at the input, decoded and applied to the cursor in
// the next cycle unless the output stalls, and the report is registered at
// the output. One byte is taken in every cycle unless the output stalls.
// The screen size is set through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. A write to either size recentres the
// cursor and keeps the packet position. Writes are to be made while idle;
// the block does not enforce it. Reset puts the size at 1024 by 768,
// centres the cursor and waits for a first byte. While the receiver
// stalls, the report holds and the input keeps taking bytes until a
// second report is ready behind it.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker
    import ps2mt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                rx_byte,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [COORD_BITS-1:0]     cursor_x,
    output logic [COORD_BITS-1:0]     cursor_y,
    output logic [BUTTON_BITS-1:0]    buttons,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SIZE_BITS-1:0]      cfg_data
);

    byte_item_t             item;
    logic                   take;
    logic                   res_valid;
    logic                   res_ready;
    logic [COORD_BITS-1:0]  res_x;
    logic [COORD_BITS-1:0]  res_y;
    logic [BUTTON_BITS-1:0] res_buttons;

    assign cfg_ready = 1'b1;

    ps2mt_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .take     (take),
        .item     (item)
    );

    ps2mt_decode #(
        .COORD_BITS (COORD_BITS)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item        (item),
        .res_ready   (res_ready),
        .take        (take),
        .res_valid   (res_valid),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_buttons (res_buttons)
    );

    ps2mt_out_reg #(
        .COORD_BITS (COORD_BITS)
    ) u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_buttons (res_buttons),
        .res_ready   (res_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cursor_x    (cursor_x),
        .cursor_y    (cursor_y),
        .buttons     (buttons)
    );

endmodule

// ----- design/ps2mt_in_reg.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker input register
// Holds one received byte until the decoder takes it.
// ----------------------------------------------------------------------------
module ps2mt_in_reg
    import ps2mt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       take,
    output byte_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= rx_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

// ----- design/ps2mt_decode.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker packet decoder
// Assembles three-byte packets, moves and clamps the cursor, and holds the
// screen size registers.
// ----------------------------------------------------------------------------
module ps2mt_decode
    import ps2mt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SIZE_BITS-1:0]      cfg_data,
    input  byte_item_t                item,
    input  logic                      res_ready,
    output logic                      take,
    output logic                      res_valid,
    output logic [COORD_BITS-1:0]     res_x,
    output logic [COORD_BITS-1:0]     res_y,
    output logic [BUTTON_BITS-1:0]    res_buttons
);

    localparam int CB = COORD_BITS;
    localparam int W  = (CB + 1 > SIZE_BITS) ? CB + 1 : SIZE_BITS;

    localparam logic [1:0] POS_HEADER = 2'd0;
    localparam logic [1:0] POS_X      = 2'd1;
    localparam logic [1:0] POS_Y      = 2'd2;

    function automatic logic [CB-1:0] axis_limit(input logic [SIZE_BITS-1:0] size);
        logic [W-1:0] cap;
        logic [W-1:0] sz;
        cap = W'(1) << CB;
        sz  = W'(size);
        if (sz > cap)
        begin
            sz = cap;
        end
        if (sz == '0)
        begin
            axis_limit = '0;
        end
        else
        begin
            axis_limit = CB'(sz - W'(1));
        end
    endfunction

    function automatic logic [CB-1:0] axis_centre(input logic [SIZE_BITS-1:0] size);
        logic [W-1:0]  half;
        logic [CB-1:0] lim;
        half = W'(size >> 1);
        lim  = axis_limit(size);
        if (half > W'(lim))
        begin
            axis_centre = lim;
        end
        else
        begin
            axis_centre = CB'(half);
        end
    endfunction

    function automatic logic [CB-1:0] axis_clamp(input logic signed [CB+1:0] v,
                                                 input logic [CB-1:0] lim);
        if (v < 0)
        begin
            axis_clamp = '0;
        end
        else if (v > $signed({2'b00, lim}))
        begin
            axis_clamp = lim;
        end
        else
        begin
            axis_clamp = v[CB-1:0];
        end
    endfunction

    localparam logic [CB-1:0] LIM_X_RST = axis_limit(SCREEN_WIDTH_RST);
    localparam logic [CB-1:0] LIM_Y_RST = axis_limit(SCREEN_HEIGHT_RST);
    localparam logic [CB-1:0] POS_X_RST = axis_centre(SCREEN_WIDTH_RST);
    localparam logic [CB-1:0] POS_Y_RST = axis_centre(SCREEN_HEIGHT_RST);

    logic [1:0]           bp_reg;
    logic [1:0]           bp_next;
    logic [7:0]           header_reg;
    logic [7:0]           header_next;
    logic [7:0]           xdelta_reg;
    logic [7:0]           xdelta_next;
    logic [CB-1:0]        pos_x_reg;
    logic [CB-1:0]        pos_x_next;
    logic [CB-1:0]        pos_y_reg;
    logic [CB-1:0]        pos_y_next;
    logic [SIZE_BITS-1:0] width_reg;
    logic [SIZE_BITS-1:0] width_next;
    logic [SIZE_BITS-1:0] height_reg;
    logic [SIZE_BITS-1:0] height_next;
    logic [CB-1:0]        lim_x_reg;
    logic [CB-1:0]        lim_x_next;
    logic [CB-1:0]        lim_y_reg;
    logic [CB-1:0]        lim_y_next;

    logic                 completes;
    logic signed [CB+1:0] sum_x;
    logic signed [CB+1:0] sum_y;
    logic [CB-1:0]        step_x;
    logic [CB-1:0]        step_y;

    // Position 3 cannot occur, but is treated like the last byte.
    assign completes = bp_reg[1];
    assign take      = item.valid && (!completes || res_ready);
    assign res_valid = take && completes;

    always_comb
    begin
        sum_x  = $signed({2'b00, pos_x_reg}) + (CB+2)'($signed(xdelta_reg));
        sum_y  = $signed({2'b00, pos_y_reg}) - (CB+2)'($signed(item.data));
        step_x = axis_clamp(sum_x, lim_x_reg);
        step_y = axis_clamp(sum_y, lim_y_reg);
    end

    assign res_x       = step_x;
    assign res_y       = step_y;
    assign res_buttons = header_reg[BUTTON_BITS-1:0];

    always_comb
    begin
        bp_next     = bp_reg;
        header_next = header_reg;
        xdelta_next = xdelta_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        width_next  = width_reg;
        height_next = height_reg;
        lim_x_next  = lim_x_reg;
        lim_y_next  = lim_y_reg;
        priority if (cfg_valid && cfg_index == REG_SCREEN_WIDTH)
        begin
            width_next = cfg_data;
            lim_x_next = axis_limit(cfg_data);
            pos_x_next = axis_centre(cfg_data);
            pos_y_next = axis_centre(height_reg);
        end
        else if (cfg_valid && cfg_index == REG_SCREEN_HEIGHT)
        begin
            height_next = cfg_data;
            lim_y_next  = axis_limit(cfg_data);
            pos_x_next  = axis_centre(width_reg);
            pos_y_next  = axis_centre(cfg_data);
        end
        else if (take)
        begin
            unique case (bp_reg)
                POS_HEADER:
                begin
                    if (item.data[SYNC_BIT])
                    begin
                        header_next = item.data;
                        bp_next     = POS_X;
                    end
                end
                POS_X:
                begin
                    xdelta_next = item.data;
                    bp_next     = POS_Y;
                end
                default:
                begin
                    bp_next    = POS_HEADER;
                    pos_x_next = step_x;
                    pos_y_next = step_y;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg     <= POS_HEADER;
            header_reg <= '0;
            xdelta_reg <= '0;
            pos_x_reg  <= POS_X_RST;
            pos_y_reg  <= POS_Y_RST;
            width_reg  <= SCREEN_WIDTH_RST;
            height_reg <= SCREEN_HEIGHT_RST;
            lim_x_reg  <= LIM_X_RST;
            lim_y_reg  <= LIM_Y_RST;
        end
        else
        begin
            bp_reg     <= bp_next;
            header_reg <= header_next;
            xdelta_reg <= xdelta_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            lim_x_reg  <= lim_x_next;
            lim_y_reg  <= lim_y_next;
        end
    end

endmodule

// ----- design/ps2mt_out_reg.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker result register
// Holds one cursor report until the receiver takes it.
// ----------------------------------------------------------------------------
module ps2mt_out_reg
    import ps2mt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   res_valid,
    input  logic [COORD_BITS-1:0]  res_x,
    input  logic [COORD_BITS-1:0]  res_y,
    input  logic [BUTTON_BITS-1:0] res_buttons,
    output logic                   res_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_BITS-1:0]  cursor_x,
    output logic [COORD_BITS-1:0]  cursor_y,
    output logic [BUTTON_BITS-1:0] buttons
);

    logic                   valid_reg;
    logic                   valid_next;
    logic [COORD_BITS-1:0]  x_reg;
    logic [COORD_BITS-1:0]  y_reg;
    logic [BUTTON_BITS-1:0] buttons_reg;

    assign res_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            x_reg       <= res_x;
            y_reg       <= res_y;
            buttons_reg <= res_buttons;
        end
    end

    assign out_valid = valid_reg;
    assign cursor_x  = x_reg;
    assign cursor_y  = y_reg;
    assign buttons   = buttons_reg;

endmodule

// ----- design/ps2mt_checker.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker port checker
// Watches the ports of the tracker for stalls and report timing.
// ----------------------------------------------------------------------------
module ps2mt_checker
    import ps2mt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [COORD_BITS-1:0]     cursor_x,
    input logic [COORD_BITS-1:0]     cursor_y,
    input logic [BUTTON_BITS-1:0]    buttons,
    input logic                      cfg_valid,
    input logic                      cfg_ready
);

    // A stalled report keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_x)
            && $stable(cursor_y) && $stable(buttons))
        else $error("report changed while stalled");

    // The input only pushes back while the receiver stalls a held report.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without an output stall");

    // A new report follows a byte accepted earlier, by way of the input and output registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("report without a recent byte");

    // The configuration port never pushes back.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind ps2_mouse_packet_cursor_tracker ps2mt_checker #(
    .COORD_BITS (COORD_BITS)
) u_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor tracker testbench
// Streams raw mouse bytes into the tracker and checks every cursor report
// against a local packet decoder. A directed table covers header sync, delta
// extremes, clamping, recentring and odd screen sizes. Random packets follow
// under several screen sizes and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb;
    import ps2mt_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int AXIS_CAP    = 1 << CB;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int SEG_ITEMS   = 155;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [CB-1:0]          x;
        logic [CB-1:0]          y;
        logic [BUTTON_BITS-1:0] btn;
    } report_t;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic [7:0]                data;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [SIZE_BITS-1:0]      val;
        logic                      typed;
        report_t                   rep;
    } row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [7:0]                rx_byte;
    logic                      out_valid;
    logic                      out_ready;
    logic [CB-1:0]             cursor_x;
    logic [CB-1:0]             cursor_y;
    logic [BUTTON_BITS-1:0]    buttons;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [SIZE_BITS-1:0]      cfg_data;

    logic [1:0]           pkt_pos;
    logic [7:0]           hdr_byte;
    logic [7:0]           dx_byte;
    logic [CB-1:0]        cur_x;
    logic [CB-1:0]        cur_y;
    logic [SIZE_BITS-1:0] scr_w;
    logic [SIZE_BITS-1:0] scr_h;

    report_t pending_reports[$];
    row_t    sync_table[$];
    int      err_count = 0;
    int      in_idle_pct = 17;
    int      out_idle_pct = 56;
    int      stall_cycles;

    ps2_mouse_packet_cursor_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cursor_x  (cursor_x),
        .cursor_y  (cursor_y),
        .buttons   (buttons),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [CB-1:0] fit_to_screen(input int v, input logic [SIZE_BITS-1:0] size);
        int lim;
        if (size == 0)
            lim = 0;
        else if (int'(size) > AXIS_CAP)
            lim = AXIS_CAP - 1;
        else
            lim = int'(size) - 1;
        if (v < 0)
            v = 0;
        if (v > lim)
            v = lim;
        return v[CB-1:0];
    endfunction

    function automatic void recentre_cursor();
        cur_x = fit_to_screen(int'(scr_w) / 2, scr_w);
        cur_y = fit_to_screen(int'(scr_h) / 2, scr_h);
    endfunction

    function automatic void apply_reg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                            input logic [SIZE_BITS-1:0] val);
        if (idx == REG_SCREEN_WIDTH)
        begin
            scr_w = val;
            recentre_cursor();
        end
        else if (idx == REG_SCREEN_HEIGHT)
        begin
            scr_h = val;
            recentre_cursor();
        end
    endfunction

    function automatic logic decode_byte(input logic [7:0] b, output report_t rep);
        int nx;
        int ny;
        rep = '0;
        if (pkt_pos == 2'd0)
        begin
            if (b[SYNC_BIT])
            begin
                hdr_byte = b;
                pkt_pos  = 2'd1;
            end
            return 1'b0;
        end
        if (pkt_pos == 2'd1)
        begin
            dx_byte = b;
            pkt_pos = 2'd2;
            return 1'b0;
        end
        pkt_pos = 2'd0;
        nx = int'(cur_x) + int'($signed(dx_byte));
        ny = int'(cur_y) - int'($signed(b));
        cur_x = fit_to_screen(nx, scr_w);
        cur_y = fit_to_screen(ny, scr_h);
        rep.x   = cur_x;
        rep.y   = cur_y;
        rep.btn = hdr_byte[BUTTON_BITS-1:0];
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (pkt_pos == 2'd0)
        begin
            if ($urandom_range(99) < 85)
                b[SYNC_BIT] = 1'b1;
        end
        else
        begin
            case ($urandom_range(9))
                0: b = 8'h7F;
                1: b = 8'h80;
                2, 3, 4: b = {{4{b[7]}}, b[3:0]};
                default: ;
            endcase
        end
        return b;
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        row_t r;
        r = '{kind: ROW_BYTE, data: b, idx: '0, val: '0, typed: 1'b0, rep: '0};
        sync_table.push_back(r);
    endfunction

    function automatic void add_report(input logic [7:0] b, input int x, input int y,
                                       input int btn);
        row_t r;
        r = '{kind: ROW_BYTE, data: b, idx: '0, val: '0, typed: 1'b1, rep: '0};
        r.rep.x   = x[CB-1:0];
        r.rep.y   = y[CB-1:0];
        r.rep.btn = btn[BUTTON_BITS-1:0];
        sync_table.push_back(r);
    endfunction

    function automatic void add_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                      input logic [SIZE_BITS-1:0] val);
        row_t r;
        r = '{kind: ROW_CFG, data: '0, idx: idx, val: val, typed: 1'b0, rep: '0};
        sync_table.push_back(r);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic typed, input report_t typed_rep);
        report_t rep;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (decode_byte(b, rep))
            pending_reports.push_back(typed ? typed_rep : rep);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [SIZE_BITS-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg_write(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected report x=%0d y=%0d buttons=%0d",
                         $time, cursor_x, cursor_y, buttons);
                err_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (cursor_x !== want.x)
                begin
                    $display("%0t: cursor_x expected %0d got %0d", $time, want.x, cursor_x);
                    err_count++;
                end
                if (cursor_y !== want.y)
                begin
                    $display("%0t: cursor_y expected %0d got %0d", $time, want.y, cursor_y);
                    err_count++;
                end
                if (buttons !== want.btn)
                begin
                    $display("%0t: buttons expected %0d got %0d", $time, want.btn, buttons);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [SIZE_BITS-1:0] seg_w[6];
        logic [SIZE_BITS-1:0] seg_h[6];
        logic [7:0]           b;
        int                   counted;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        scr_w    = SCREEN_WIDTH_RST;
        scr_h    = SCREEN_HEIGHT_RST;
        pkt_pos  = 2'd0;
        hdr_byte = '0;
        dx_byte  = '0;
        recentre_cursor();

        add_byte(8'h00);
        add_byte(8'hF7);
        add_byte(8'h08);
        add_byte(8'h00);
        add_report(8'h00, 512, 384, 0);
        add_byte(8'h0F);
        add_byte(8'h7F);
        add_report(8'h80, 639, 512, 7);
        add_byte(8'hFF);
        add_byte(8'h80);
        add_report(8'h7F, 511, 385, 7);
        add_byte(8'h09);
        add_byte(8'h01);
        add_report(8'hFF, 512, 386, 1);
        add_write(REG_SCREEN_WIDTH, 13'd0);
        add_byte(8'h0A);
        add_byte(8'h05);
        add_report(8'h03, 0, 381, 2);
        add_write(REG_SCREEN_HEIGHT, 13'h1FFF);
        add_byte(8'h0C);
        add_byte(8'h10);
        add_report(8'h80, 0, 4095, 4);
        add_write(REG_SPARE_2, 13'd1);
        add_write(REG_SPARE_3, 13'h1FFF);
        add_write(REG_SCREEN_WIDTH, 13'd1);
        add_byte(8'h08);
        add_byte(8'h7F);
        add_report(8'h7F, 0, 3968, 0);
        add_write(REG_SCREEN_WIDTH, 13'd4096);
        add_write(REG_SCREEN_HEIGHT, 13'd1);
        add_byte(8'h0B);
        add_byte(8'h81);
        add_report(8'h01, 1921, 0, 3);

        seg_w = '{13'h1555, 13'd64, 13'd4096, 13'd1, 13'd0, 13'h1FFF};
        seg_h = '{13'h0AAA, 13'd48, 13'd4096, 13'd2, 13'd0, 13'd3};
        seg_w[4] = SIZE_BITS'($urandom_range(1, 4096));
        seg_h[4] = SIZE_BITS'($urandom_range(1, 4096));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (sync_table[i])
        begin
            if (sync_table[i].kind == ROW_CFG)
                write_reg(sync_table[i].idx, sync_table[i].val);
            else
                push_byte(sync_table[i].data, sync_table[i].typed, sync_table[i].rep);
        end

        for (int seg = 0; seg < 6; seg++)
        begin
            in_idle_pct  = (seg < 2) ? 17 : (seg < 4) ? 56 : 0;
            out_idle_pct = (seg < 2) ? 56 : (seg < 4) ? 17 : 0;
            write_reg(REG_SCREEN_WIDTH, seg_w[seg]);
            write_reg(REG_SCREEN_HEIGHT, seg_h[seg]);
            counted = 0;
            while (counted < SEG_ITEMS)
            begin
                b = pick_byte();
                if (pkt_pos != 2'd0 || b[SYNC_BIT])
                    counted++;
                push_byte(b, 1'b0, '0);
            end
        end

        settle();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
